@@ rtl/core/odq_pkg.sv @@
// -----------------------------------------------------------------------------
// odq_pkg: shared definitions for the output-restricted deque core
// Holds the depth, the field widths, the operation and status codes, and the
// command word that the top level sends to each storage cell.
// -----------------------------------------------------------------------------
package odq_pkg;

    // Storage depth and derived widths.
    localparam int DEPTH   = 16;
    localparam int DATA_W  = 32;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
    localparam logic [OP_W-1:0] OP_PUSH_REAR  = 2'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd2;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    // Per-cell command: take the new word, take the front-side neighbor,
    // or take the rear-side neighbor.
    typedef struct packed {
        logic load;
        logic shift_from_front;
        logic shift_from_rear;
    } cell_cmd_t;

endpackage

@@ rtl/core/output_restricted_deque_core.sv @@
// -----------------------------------------------------------------------------
// output_restricted_deque_core: output-restricted deque of signed words
// The front entry always sits in cell 0. A push at the front shifts the chain
// toward the rear, a pop shifts it toward the front, and a push at the rear
// writes the cell just past the last occupied one.
//
//   Channel   Handshake          Payload
//   -------   ----------------   ---------------------------------------------
//   command   start / busy       op, push_value
//   result    done (strobe)      popped_value, status, now_empty, now_full
//
// The result strobe is raised in the cycle after the command is accepted, and
// a new item may be accepted at every edge, so busy stays low. Each item is
// completed by the single update of the cell chain and entry count.
// Reset clears the entry count and the result strobe; cell contents are
// undefined until written. The receiver cannot stall results.
// -----------------------------------------------------------------------------
module output_restricted_deque_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [odq_pkg::OP_W-1:0]           op,
    input  logic signed [odq_pkg::DATA_W-1:0]  push_value,
    output logic                               busy,
    output logic                               done,
    output logic signed [odq_pkg::DATA_W-1:0]  popped_value,
    output logic [odq_pkg::STAT_W-1:0]         status,
    output logic                               now_empty,
    output logic                               now_full
);

    logic                               accept;
    logic                               is_full;
    logic                               is_empty;
    logic [odq_pkg::CNT_W-1:0]          count_reg;
    logic [odq_pkg::CNT_W-1:0]          count_next;
    logic                               do_push_front;
    logic                               do_push_rear;
    logic                               do_pop;
    logic signed [odq_pkg::DATA_W-1:0]  value_next;
    logic [odq_pkg::STAT_W-1:0]         status_next;

    logic                               done_reg;
    logic signed [odq_pkg::DATA_W-1:0]  popped_value_reg;
    logic [odq_pkg::STAT_W-1:0]         status_reg;
    logic                               now_empty_reg;
    logic                               now_full_reg;

    logic signed [odq_pkg::DATA_W-1:0]  cell_data [odq_pkg::DEPTH];
    odq_pkg::cell_cmd_t                 cell_cmd  [odq_pkg::DEPTH];

    // No item holds off the next one, so busy is tied low.
    assign busy     = 1'b0;
    assign accept   = start & ~busy;
    assign is_full  = (count_reg == odq_pkg::CNT_W'(odq_pkg::DEPTH));
    assign is_empty = (count_reg == '0);

    // Decode the operation against the current fill level.
    always_comb
    begin
        do_push_front = 1'b0;
        do_push_rear  = 1'b0;
        do_pop        = 1'b0;
        status_next   = odq_pkg::ST_DONE;
        value_next    = '0;
        count_next    = count_reg;
        if (accept)
        begin
            case (op)
                odq_pkg::OP_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        status_next = odq_pkg::ST_FULL;
                    end
                    else
                    begin
                        do_push_front = 1'b1;
                        count_next    = count_reg + 1'b1;
                    end
                end
                odq_pkg::OP_PUSH_REAR:
                begin
                    if (is_full)
                    begin
                        status_next = odq_pkg::ST_FULL;
                    end
                    else
                    begin
                        do_push_rear = 1'b1;
                        count_next   = count_reg + 1'b1;
                    end
                end
                odq_pkg::OP_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        status_next = odq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        do_pop     = 1'b1;
                        value_next = cell_data[0];
                        count_next = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    status_next = odq_pkg::ST_DONE;
                end
            endcase
        end
    end

    // Chain of cells, front entry in cell 0.
    for (genvar i = 0; i < odq_pkg::DEPTH; i++)
    begin : g_cell
        logic signed [odq_pkg::DATA_W-1:0] front_side;
        logic signed [odq_pkg::DATA_W-1:0] rear_side;

        if (i == 0)
        begin : g_first
            assign front_side = push_value;
        end
        else
        begin : g_mid_front
            assign front_side = cell_data[i-1];
        end

        if (i == odq_pkg::DEPTH - 1)
        begin : g_last
            assign rear_side = cell_data[i];
        end
        else
        begin : g_mid_rear
            assign rear_side = cell_data[i+1];
        end

        // A rear push writes the first free cell.
        assign cell_cmd[i].load =
            do_push_rear & (count_reg == odq_pkg::CNT_W'(i));
        assign cell_cmd[i].shift_from_front = do_push_front;
        assign cell_cmd[i].shift_from_rear  = do_pop;

        odq_cell u_cell
        (
            .clk        (clk),
            .cmd        (cell_cmd[i]),
            .new_word   (push_value),
            .front_data (front_side),
            .rear_data  (rear_side),
            .data       (cell_data[i])
        );
    end

    // Entry count and result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    // Result payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            popped_value_reg <= value_next;
            status_reg       <= status_next;
            now_empty_reg    <= (count_next == '0);
            now_full_reg     <= (count_next == odq_pkg::CNT_W'(odq_pkg::DEPTH));
        end
    end

    assign done         = done_reg;
    assign popped_value = popped_value_reg;
    assign status       = status_reg;
    assign now_empty    = now_empty_reg;
    assign now_full     = now_full_reg;

endmodule

@@ rtl/core/odq_cell.sv @@
// -----------------------------------------------------------------------------
// odq_cell: one storage cell of the deque chain
// Holds one word and takes a new value from the pushed word or from either
// neighbor, as commanded.
// -----------------------------------------------------------------------------
module odq_cell
(
    input  logic                              clk,
    input  odq_pkg::cell_cmd_t                cmd,
    input  logic signed [odq_pkg::DATA_W-1:0] new_word,
    input  logic signed [odq_pkg::DATA_W-1:0] front_data,
    input  logic signed [odq_pkg::DATA_W-1:0] rear_data,
    output logic signed [odq_pkg::DATA_W-1:0] data
);

    logic signed [odq_pkg::DATA_W-1:0] data_reg;
    logic signed [odq_pkg::DATA_W-1:0] data_next;

    // Select the value this cell holds after the step.
    always_comb
    begin
        data_next = data_reg;
        if (cmd.load)
        begin
            data_next = new_word;
        end
        else if (cmd.shift_from_front)
        begin
            data_next = front_data;
        end
        else if (cmd.shift_from_rear)
        begin
            data_next = rear_data;
        end
    end

    // Payload register; contents are undefined until written.
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule
